// File: src/circular_deque_macros.svh
// Assertion macros used by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define CDQ_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define CDQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cdq_pkg.sv
// Package with the types, constants and command codes of the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    // Ring geometry.
    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LIMIT_W = 7;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int DATA_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    // Command codes.
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK       = 3'd4
    } cdq_cmd_t;

    // Request payload.
    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] push_value;
    } cdq_req_t;

    // Response payload.
    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } cdq_rsp_t;

    // Flags carried alongside the RAM read while the read data settles.
    typedef struct packed {
        logic              accepted;
        logic              is_empty;
        logic              is_full;
        logic              front_byp;
        logic              rear_byp;
        logic [DATA_W-1:0] byp_value;
    } cdq_s1_t;

endpackage

// File: src/circular_deque.sv
// Top level of the circular deque: control, ring indices and response pipeline.
`timescale 1ns / 1ps
`include "circular_deque_macros.svh"

// Usage:
// A request carries a command (push front, push back, pop front, pop back,
// peek) and a value used by pushes. It is taken at a clock edge where
// req_valid is high and req_stall is low. Every request gives exactly one
// response on rsp_data, taken where rsp_valid is high and rsp_stall is low.
// The response reports whether the command was done and the front, rear,
// empty and full state after it; front and rear read all ones when empty.
// Throughput is one request per cycle while req_stall is low. The indices
// update and the ring RAM is read in the accepting cycle, the read data
// and flags wait in the read stage, and the response register loads from
// there once it is free or being taken. A write bypass covers the RAM read.
// If the receiver stalls, one finished response waits in the output
// register and one more in the read stage; req_stall rises only when both
// are full. Reset empties the deque and sets the capacity limit to 64;
// the ring contents are not cleared. cfg_we writes the capacity limit and
// must be used only while the block is idle; the block does not enforce it.
module circular_deque
    import cdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               req_valid,
    output logic               req_stall,
    input  cdq_req_t           req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cdq_rsp_t           rsp_data
);

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               s1_valid_reg, s1_valid_next;
    cdq_s1_t            s1_reg, s1_next;
    logic               rsp_valid_reg, rsp_valid_next;
    cdq_rsp_t           rsp_reg, rsp_next;

    logic [CMP_W-1:0]   eff_limit;
    logic               full_now, empty_now;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   rear_addr;
    logic               cmd_ok;
    logic               req_accept, rsp_ready, rsp_load;
    logic [DATA_W-1:0]  ram_front, ram_rear;

    // Index steps with wrap at the ring depth.
    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
        step_up = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
        step_down = (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

    // Handshake: two response slots, ready flows back from the receiver.
    assign rsp_ready  = !rsp_valid_reg || !rsp_stall;
    assign rsp_load   = s1_valid_reg && rsp_ready;
    assign req_stall  = s1_valid_reg && !rsp_ready;
    assign req_accept = req_valid && !req_stall;

    // Limits above the ring depth act as the depth.
    assign eff_limit = (CMP_W'(limit_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                            : CMP_W'(limit_reg);
    assign full_now  = CMP_W'(count_reg) >= eff_limit;
    assign empty_now = count_reg == '0;

    // Command decode and the next ring state.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cmd_ok     = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        case (req_data.command)
            CMD_PUSH_FRONT:
            begin
                if (!full_now)
                begin
                    head_next  = step_down(head_reg);
                    wr_addr    = step_down(head_reg);
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    cmd_ok     = 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (!full_now)
                begin
                    wr_addr    = tail_reg;
                    wr_en      = 1'b1;
                    tail_next  = step_up(tail_reg);
                    count_next = count_reg + CNT_W'(1);
                    cmd_ok     = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (!empty_now)
                begin
                    head_next  = step_up(head_reg);
                    count_next = count_reg - CNT_W'(1);
                    cmd_ok     = 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (!empty_now)
                begin
                    tail_next  = step_down(tail_reg);
                    count_next = count_reg - CNT_W'(1);
                    cmd_ok     = 1'b1;
                end
            end
            CMD_PEEK:
            begin
                cmd_ok = 1'b1;
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
        rear_addr = step_down(tail_next);
    end

    // Flags for the read stage; a write this cycle bypasses the RAM read.
    always_comb
    begin
        s1_next.accepted  = cmd_ok;
        s1_next.is_empty  = count_next == '0;
        s1_next.is_full   = CMP_W'(count_next) >= eff_limit;
        s1_next.front_byp = wr_en && (wr_addr == head_next);
        s1_next.rear_byp  = wr_en && (wr_addr == rear_addr);
        s1_next.byp_value = req_data.push_value;
    end

    cdq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ring (
        .clk    (clk),
        .we     (req_accept && wr_en),
        .waddr  (wr_addr),
        .wdata  (req_data.push_value),
        .re     (req_accept),
        .raddr_a(head_next),
        .raddr_b(rear_addr),
        .rdata_a(ram_front),
        .rdata_b(ram_rear)
    );

    // Response assembly from the read stage.
    always_comb
    begin
        rsp_next.accepted = s1_reg.accepted;
        rsp_next.is_empty = s1_reg.is_empty;
        rsp_next.is_full  = s1_reg.is_full;
        if (s1_reg.is_empty)
        begin
            rsp_next.front_value = '1;
            rsp_next.rear_value  = '1;
        end
        else
        begin
            rsp_next.front_value = s1_reg.front_byp ? s1_reg.byp_value : ram_front;
            rsp_next.rear_value  = s1_reg.rear_byp ? s1_reg.byp_value : ram_rear;
        end
    end

    // Valid bits of the two response slots.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (rsp_load)
        begin
            s1_valid_next = 1'b0;
        end
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_reg <= s1_next;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // The entry count never exceeds the ring depth.
    `CDQ_ASSERT(a_count_bound, CNT_W'(count_reg) <= CNT_W'(DEPTH), "entry count above depth")
    // An accepted request always occupies the read stage next cycle.
    `CDQ_ASSERT_NEXT(a_s1_fill, req_accept, s1_valid_reg, "accepted request lost")
    // An empty response reports all ones at both ends.
    `CDQ_ASSERT(a_empty_ends, !(rsp_valid && rsp_data.is_empty) || ((rsp_data.front_value == -1) && (rsp_data.rear_value == -1)), "empty response ends not all ones")

endmodule

// File: src/cdq_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the contents from before a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the circular deque: directed and random requests with a scoreboard.
`timescale 1ns / 1ps

module tb;
    import cdq_pkg::*;

    // Command codes that the block must refuse without any change.
    localparam logic [2:0] FIRST_UNUSED_CMD = 3'd5;
    localparam logic [2:0] MID_UNUSED_CMD   = 3'd6;
    localparam logic [2:0] LAST_UNUSED_CMD  = 3'd7;

    // Cycles with no handshake on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 4000;
    // Length of the long receiver hold-off that fills the pipeline.
    localparam int HOLD_CYCLES = 80;
    // Pipeline depth plus margin, waited out before a capacity write and at the end.
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // Mirror of the deque contents; computes the status of each request and checks responses.
    class deque_scoreboard;
        logic signed [DATA_W-1:0] slots [DEPTH];
        int unsigned              front_at;
        int unsigned              back_after;
        int unsigned              held;
        logic [LIMIT_W-1:0]       cap;
        cdq_rsp_t                 pending_status [$];
        int unsigned              mismatches;
        int unsigned              commands;
        int unsigned              refused;
        int unsigned              full_seen;
        int unsigned              empty_seen;

        function new();
            front_at   = 0;
            back_after = 0;
            held       = 0;
            cap        = LIMIT_RESET;
            mismatches = 0;
            commands   = 0;
            refused    = 0;
            full_seen  = 0;
            empty_seen = 0;
        endfunction

        // Applies one accepted request to the mirror and queues the status it should produce.
        function void note_command(cdq_req_t r);
            cdq_rsp_t    want;
            int unsigned room;
            bit          done;
            room = (cap > DEPTH) ? DEPTH : cap;
            done = 1'b0;
            case (r.command)
                CMD_PUSH_FRONT:
                begin
                    if (held < room)
                    begin
                        front_at = (front_at == 0) ? DEPTH - 1 : front_at - 1;
                        slots[front_at] = r.push_value;
                        held++;
                        done = 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (held < room)
                    begin
                        slots[back_after] = r.push_value;
                        back_after = (back_after + 1 >= DEPTH) ? 0 : back_after + 1;
                        held++;
                        done = 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (held != 0)
                    begin
                        front_at = (front_at + 1 >= DEPTH) ? 0 : front_at + 1;
                        held--;
                        done = 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (held != 0)
                    begin
                        back_after = (back_after == 0) ? DEPTH - 1 : back_after - 1;
                        held--;
                        done = 1'b1;
                    end
                end
                CMD_PEEK:
                begin
                    done = 1'b1;
                end
                default:
                begin
                end
            endcase

            want.accepted = done;
            want.is_empty = (held == 0);
            want.is_full  = (held >= room);
            if (held == 0)
            begin
                want.front_value = '1;
                want.rear_value  = '1;
            end
            else
            begin
                want.front_value = slots[front_at];
                want.rear_value  = slots[(back_after == 0) ? DEPTH - 1 : back_after - 1];
            end
            commands++;
            if (!done)
                refused++;
            if (want.is_full)
                full_seen++;
            if (want.is_empty)
                empty_seen++;
            pending_status.push_back(want);
        endfunction

        function void match_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] seen);
            if (want !== seen)
            begin
                $error("%s expected %0d actual %0d", name, $signed(want), $signed(seen));
                mismatches++;
            end
        endfunction

        // Compares one response with the oldest queued status.
        function void check_status(cdq_rsp_t got);
            cdq_rsp_t want;
            if (pending_status.size() == 0)
            begin
                $error("response arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_status.pop_front();
            match_field("accepted", DATA_W'(want.accepted), DATA_W'(got.accepted));
            match_field("front_value", want.front_value, got.front_value);
            match_field("rear_value", want.rear_value, got.rear_value);
            match_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
            match_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    cdq_req_t           req_data = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    cdq_rsp_t           rsp_data;

    deque_scoreboard board;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_order = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  backpressure_cycles = 0;
    int  settings = 0;

    circular_deque dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is ordered.
    always @(posedge clk)
    begin
        if (hold_order)
        begin
            hold_left = HOLD_CYCLES;
            hold_order = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: feeds accepted requests to the scoreboard and checks accepted responses.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.note_command(req_data);
            if (rsp_valid && !rsp_stall)
                board.check_status(rsp_data);
            if (req_valid && req_stall)
                backpressure_cycles++;
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog on progress.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic cdq_req_t cmd_item(input logic [2:0] cmd, input logic [DATA_W-1:0] val);
        cdq_req_t r;
        r.command    = cmd;
        r.push_value = val;
        return r;
    endfunction

    // Random request; push_pct steers the fill level up or down.
    function automatic cdq_req_t random_req(input int push_pct);
        cdq_req_t r;
        int       roll;
        r.push_value = $urandom();
        roll = $urandom_range(99);
        if (roll < 3)
            r.command = 3'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));
        else if (roll < 12)
            r.command = CMD_PEEK;
        else if (roll < 12 + push_pct * 88 / 100)
            r.command = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else
            r.command = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        return r;
    endfunction

    // Offers one request after an optional random gap and holds it until it is taken.
    task automatic send_req(input cdq_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Stops offering and waits until every response is back and the pipeline is quiet.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the capacity limit while the block is idle.
    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.cap = value;
        settings++;
    endtask

    // One random phase: a capacity setting, an idling pattern and bursts of biased traffic.
    task automatic random_phase(input logic [LIMIT_W-1:0] limit, input idle_mode_t mode,
                                input int items, input bit squeeze);
        int left;
        int burst;
        int bias;
        int room;
        set_limit(limit);
        send_idle_pct  = (mode == IDLE_SEND) ? 85 : (mode == IDLE_BOTH) ? 11 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 85 : (mode == IDLE_BOTH) ? 11 : 0;
        if (squeeze)
            hold_order = 1'b1;
        room = (limit > DEPTH) ? DEPTH : limit;
        left = items;
        while (left > 0)
        begin
            burst = $urandom_range(8, 2 * room + 16);
            if (burst > left)
                burst = left;
            case ($urandom_range(2))
                0: bias = 85;
                1: bias = 15;
                default: bias = 50;
            endcase
            repeat (burst) send_req(random_req(bias));
            left -= burst;
        end
    endtask

    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque at the reset limit: refused pops, unused codes, extreme values.
        send_req(cmd_item(CMD_PEEK, $urandom()));
        send_req(cmd_item(CMD_POP_FRONT, $urandom()));
        send_req(cmd_item(CMD_POP_BACK, $urandom()));
        send_req(cmd_item(FIRST_UNUSED_CMD, $urandom()));
        send_req(cmd_item(LAST_UNUSED_CMD, $urandom()));
        send_req(cmd_item(CMD_PUSH_FRONT, 32'h7FFF_FFFF));
        send_req(cmd_item(CMD_PUSH_BACK, 32'h8000_0000));
        send_req(cmd_item(CMD_PUSH_FRONT, 32'h0000_0000));
        send_req(cmd_item(CMD_PUSH_BACK, 32'hFFFF_FFFF));
        send_req(cmd_item(CMD_PEEK, $urandom()));
        send_req(cmd_item(CMD_POP_FRONT, $urandom()));
        send_req(cmd_item(CMD_POP_BACK, $urandom()));
        send_req(cmd_item(CMD_POP_BACK, $urandom()));
        send_req(cmd_item(CMD_POP_FRONT, $urandom()));

        // Small limit: fill up and get a push refused.
        set_limit(LIMIT_W'(2));
        send_req(cmd_item(CMD_PUSH_BACK, 32'hAAAA_AAAA));
        send_req(cmd_item(CMD_PUSH_FRONT, 32'h5555_5555));
        send_req(cmd_item(CMD_PUSH_BACK, $urandom()));

        // Limit of zero below the held count: entries stay, pushes are refused.
        set_limit(LIMIT_W'(0));
        send_req(cmd_item(CMD_PEEK, $urandom()));
        send_req(cmd_item(CMD_PUSH_FRONT, $urandom()));
        send_req(cmd_item(CMD_POP_FRONT, $urandom()));
        send_req(cmd_item(CMD_POP_BACK, $urandom()));
        send_req(cmd_item(CMD_PUSH_BACK, $urandom()));

        // Limit above the ring size acts as the ring size.
        set_limit('1);
        send_req(cmd_item(CMD_PUSH_BACK, 32'h0000_0001));
        send_req(cmd_item(CMD_POP_FRONT, $urandom()));
        send_req(cmd_item(MID_UNUSED_CMD, $urandom()));

        // Random phases over capacity settings and idling patterns.
        random_phase('1, IDLE_NONE, 150, 1'b0);
        random_phase(LIMIT_W'(1), IDLE_SEND, 120, 1'b0);
        random_phase(LIMIT_W'(DEPTH), IDLE_RECV, 200, 1'b0);
        random_phase(LIMIT_W'(3), IDLE_BOTH, 130, 1'b0);
        random_phase(LIMIT_W'($urandom_range(1, DEPTH)), IDLE_NONE, 150, 1'b1);
        random_phase(LIMIT_W'(0), IDLE_BOTH, 40, 1'b0);
        random_phase(LIMIT_W'(DEPTH), IDLE_BOTH, 200, 1'b0);
        random_phase(LIMIT_W'($urandom_range(4, 20)), IDLE_SEND, 150, 1'b0);
        random_phase('1, IDLE_RECV, 150, 1'b0);
        random_phase(LIMIT_W'(2), IDLE_NONE, 60, 1'b0);

        recv_stall_pct = 0;
        drain();

        $display("Checked %0d requests over %0d limits: %0d refused, %0d full, %0d empty.",
                 board.commands, settings, board.refused, board.full_seen, board.empty_seen);
        $display("Input was held back for %0d cycles under receiver stalls.", backpressure_cycles);
        if (board.mismatches == 0 && board.pending_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/cdq_pkg.sv
src/cdq_ram.sv
src/circular_deque.sv
dv/tb.sv
